/* rtl/inertial_dead_reckoning_defines.svh */
// Assertion macros for the dead reckoning block.
`ifndef INERTIAL_DEAD_RECKONING_DEFINES_SVH
`define INERTIAL_DEAD_RECKONING_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define IDR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define IDR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/idr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dead reckoning package
// Shared constants and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package idr_pkg;
    localparam int Window     = 50;
    localparam int SlotW      = $clog2(Window + 1);
    localparam int AddrW      = $clog2(Window);
    localparam int SumW       = 16 + $clog2(Window + 1);
    localparam logic [14:0] GravityReset = 15'd2511;
    localparam logic [0:0]  RegGravity   = 1'b0;

    // Datapath operations, one per controller step.
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_ROT, OP_WRD, OP_SUM, OP_DIV, OP_POS1, OP_POS2,
        OP_POS3, OP_VEL, OP_DONE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_busy;
    } t_stat;
endpackage
`default_nettype wire

/* rtl/idr_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Input and output stream interfaces
// Valid/ready channels for the samples and for the navigation results.
// ----------------------------------------------------------------------------
interface idr_in_if;
    logic        valid;
    logic        ready;
    logic [47:0] rot_row0;
    logic [47:0] rot_row1;
    logic [47:0] rot_row2;
    logic signed [15:0] body_acc_x;
    logic signed [15:0] body_acc_y;
    logic signed [15:0] body_acc_z;
    logic [31:0] time_stamp;
    modport source (output valid, rot_row0, rot_row1, rot_row2, body_acc_x,
                    body_acc_y, body_acc_z, time_stamp, input ready);
    modport sink (input valid, rot_row0, rot_row1, rot_row2, body_acc_x,
                  body_acc_y, body_acc_z, time_stamp, output ready);
endinterface

interface idr_out_if;
    logic        valid;
    logic        ready;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [47:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [15:0] smooth_acc_x;
    logic signed [15:0] smooth_acc_y;
    logic signed [15:0] smooth_acc_z;
    modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    smooth_acc_x, smooth_acc_y, smooth_acc_z, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  smooth_acc_x, smooth_acc_y, smooth_acc_z, output ready);
endinterface
`default_nettype wire

/* rtl/idr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dead reckoning controller
// Sequences the datapath through one sample, axis by axis.
// ----------------------------------------------------------------------------
module idr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire idr_pkg::t_stat i_stat,
    output idr_pkg::t_cmd      o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT} t_state;

    t_state         r_state, n_state;
    idr_pkg::t_cmd  r_cmd, n_cmd;

    assign o_cmd      = r_cmd;
    assign o_in_ready = (r_state == S_IDLE) && !i_stat.out_busy;

    always_comb begin
        n_state = r_state;
        n_cmd   = '{op: idr_pkg::OP_NONE, axis: r_cmd.axis};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_state = S_RUN;
                    n_cmd   = '{op: idr_pkg::OP_LOAD, axis: 2'd0};
                end
            end
            S_RUN: begin
                n_cmd = r_cmd;
                unique case (r_cmd.op)
                    idr_pkg::OP_LOAD: n_cmd.op = idr_pkg::OP_ROT;
                    idr_pkg::OP_ROT: begin
                        if (r_cmd.axis == 2'd2) begin
                            n_cmd = '{op: idr_pkg::OP_WRD, axis: 2'd0};
                        end else begin
                            n_cmd.axis = r_cmd.axis + 2'd1;
                        end
                    end
                    idr_pkg::OP_WRD: n_cmd.op = idr_pkg::OP_SUM;
                    idr_pkg::OP_SUM: n_cmd.op = idr_pkg::OP_DIV;
                    idr_pkg::OP_DIV: begin
                        n_cmd.op = idr_pkg::OP_NONE;
                        n_state  = S_WAIT;
                    end
                    idr_pkg::OP_POS1: n_cmd.op = idr_pkg::OP_POS2;
                    idr_pkg::OP_POS2: n_cmd.op = idr_pkg::OP_POS3;
                    idr_pkg::OP_POS3: n_cmd.op = idr_pkg::OP_VEL;
                    idr_pkg::OP_VEL: begin
                        if (r_cmd.axis == 2'd2) begin
                            n_cmd.op = idr_pkg::OP_DONE;
                        end else begin
                            n_cmd = '{op: idr_pkg::OP_WRD, axis: r_cmd.axis + 2'd1};
                        end
                    end
                    idr_pkg::OP_DONE: begin
                        n_cmd.op = idr_pkg::OP_NONE;
                        n_state  = S_IDLE;
                    end
                    default: n_cmd.op = idr_pkg::OP_NONE;
                endcase
            end
            S_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_RUN;
                    n_cmd.op = idr_pkg::OP_POS1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= '{op: idr_pkg::OP_NONE, axis: 2'd0};
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
        end
    end
endmodule
`default_nettype wire

/* rtl/idr_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dead reckoning datapath
// Rotation, moving-average window, divider and integrators, one axis at a time.
// ----------------------------------------------------------------------------
module idr_dpath (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire idr_pkg::t_cmd  i_cmd,
    input  wire logic           i_in_ready,
    output idr_pkg::t_stat      o_stat,
    input  wire logic [14:0]    i_gravity,
    idr_in_if.sink              in_if,
    idr_out_if.source           out_if
);
    localparam int DivW = idr_pkg::SumW + 1;
    localparam int CntW = $clog2(DivW + 1);

    // Sample latch.
    logic [47:0]        r_row [3];
    logic signed [15:0] r_body [3];
    logic [31:0]        r_dt, r_last;
    logic signed [15:0] r_glob [3];

    // Window memories, one per axis, read data registered.
    logic signed [15:0] r_win [3][idr_pkg::Window];
    logic signed [15:0] r_old;
    logic [idr_pkg::SlotW-1:0] r_fill, r_slot;
    logic r_full;
    logic signed [idr_pkg::SumW-1:0] r_sum [3];

    // Velocity, position, smoothed acceleration.
    logic signed [31:0] r_vel [3];
    logic signed [47:0] r_pos [3];
    logic signed [15:0] r_sacc [3];
    logic signed [15:0] r_sacc_old [3];

    // Divider.
    logic               r_dbusy, r_dneg;
    logic [1:0]         r_daxis;
    logic [CntW-1:0]    r_dcnt;
    logic [DivW-1:0]    r_dnum, r_drem, r_dq;
    logic [DivW-1:0]    r_dden;
    logic [1:0]         r_dpend;

    // Integrator scratch.
    logic [63:0] r_p1, r_p2, r_p3;
    logic        r_obusy;

    logic [1:0] ax;
    assign ax = i_cmd.axis;
    assign o_stat = '{div_busy: r_dbusy || (r_dpend != 2'd0), out_busy: r_obusy};
    assign in_if.ready = i_in_ready;

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767) return 16'sh7fff;
        if (v < -20'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Rotation: column j of the matrix against the body vector.
    logic signed [33:0] rot_s;
    logic [33:0]        rot_m;
    logic signed [19:0] rot_g;
    always_comb begin
        rot_s = 34'(signed'(r_row[0][16*ax +: 16]) * r_body[0])
              + 34'(signed'(r_row[1][16*ax +: 16]) * r_body[1])
              + 34'(signed'(r_row[2][16*ax +: 16]) * r_body[2]);
        rot_m = rot_s[33] ? 34'(-rot_s) : rot_s;
        rot_m = (rot_m + 34'd8192) >> 14;
        rot_g = rot_s[33] ? -20'(signed'(rot_m[19:0])) : 20'(signed'(rot_m[19:0]));
        if (ax == 2'd2) begin
            rot_g = rot_g - 20'(signed'({1'b0, i_gravity}));
        end
    end

    // Integrator arithmetic: magnitude times dt with rounding on a k-bit shift.
    logic [47:0] mag_a;
    logic [31:0] mag_v, mag_s;
    logic        sg_a, sg_v;
    logic signed [15:0] sa_cur;
    always_comb begin
        sa_cur = r_sacc_old[ax];
        sg_a   = sa_cur[15];
        mag_s  = sg_a ? 32'(-32'(sa_cur)) : 32'(sa_cur);
        sg_v   = r_vel[ax][31];
        mag_v  = sg_v ? 32'(-r_vel[ax]) : 32'(r_vel[ax]);
        mag_a  = r_p1[47:0];
    end

    // The a*dt*dt product is split at bit 25 of a*dt, so the rounded term is
    // the high product plus the rounded low product shifted down.
    logic signed [56:0] pos_n;
    logic signed [40:0] vel_n;
    logic [63:0] t1_q, t2_q, dv_q;
    logic [63:0] dv_p;
    logic [15:0] mag_new;
    always_comb begin
        t1_q  = r_p3 + ((r_p2 + 64'h1000000) >> 25);
        t2_q  = (r_p1 + 64'h8000) >> 16;
        pos_n = 57'(r_pos[ax]) + (sg_a ? -57'(t1_q) : 57'(t1_q))
              + (sg_v ? -57'(t2_q) : 57'(t2_q));
        mag_new = r_sacc[ax][15] ? 16'(-r_sacc[ax]) : 16'(r_sacc[ax]);
        dv_p  = 64'(mag_new) * 64'(r_dt);
        dv_q  = (dv_p + 64'h80) >> 8;
        vel_n = 41'(r_vel[ax]) + (r_sacc[ax][15] ? -41'(dv_q[39:0]) : 41'(dv_q[39:0]));
    end

    logic [DivW-1:0] d_try;
    assign d_try = {r_drem[DivW-2:0], r_dnum[DivW-1]};

    always_ff @(posedge i_clk) begin
        // Window memory port: write and registered read.
        if (i_cmd.op == idr_pkg::OP_WRD) begin
            r_old <= r_win[ax][r_slot[idr_pkg::AddrW-1:0]];
        end
        if (i_cmd.op == idr_pkg::OP_SUM) begin
            r_win[ax][r_slot[idr_pkg::AddrW-1:0]] <= r_glob[ax];
        end
        // The sample is taken on the accepting edge itself.
        if (in_if.valid && i_in_ready) begin
            r_row[0] <= in_if.rot_row0;
            r_row[1] <= in_if.rot_row1;
            r_row[2] <= in_if.rot_row2;
            r_body[0] <= in_if.body_acc_x;
            r_body[1] <= in_if.body_acc_y;
            r_body[2] <= in_if.body_acc_z;
        end
        unique case (i_cmd.op)
            idr_pkg::OP_ROT: r_glob[ax] <= sat16(rot_g);
            idr_pkg::OP_POS1: begin
                r_p1 <= 64'(mag_s) * 64'(r_dt);
            end
            idr_pkg::OP_POS2: begin
                r_p2 <= 64'(mag_a[24:0]) * 64'(r_dt);
                r_p3 <= 64'(mag_a[47:25]) * 64'(r_dt);
                r_p1 <= 64'(mag_v) * 64'(r_dt);
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_last <= '0;
            r_dt   <= '0;
            r_fill <= '0;
            r_slot <= '0;
            r_full <= 1'b0;
            r_obusy <= 1'b0;
            r_dbusy <= 1'b0;
            r_dpend <= '0;
            for (int k = 0; k < 3; k++) begin
                r_sum[k]  <= '0;
                r_vel[k]  <= '0;
                r_pos[k]  <= '0;
                r_sacc[k] <= '0;
                r_sacc_old[k] <= '0;
            end
        end else begin
            if (out_if.valid && out_if.ready) r_obusy <= 1'b0;
            if (in_if.valid && i_in_ready) begin
                r_dt   <= in_if.time_stamp - r_last;
                r_last <= in_if.time_stamp;
            end
            unique case (i_cmd.op)
                idr_pkg::OP_LOAD: begin
                    for (int k = 0; k < 3; k++) r_sacc_old[k] <= r_sacc[k];
                end
                idr_pkg::OP_SUM: begin
                    r_sum[ax] <= r_sum[ax] + idr_pkg::SumW'(r_glob[ax])
                               - (r_full ? idr_pkg::SumW'(r_old) : '0);
                    r_dpend <= 2'd1;
                    r_daxis <= ax;
                end
                idr_pkg::OP_POS3: begin
                    if (pos_n > 57'sh7fffffffffff) r_pos[ax] <= 48'sh7fffffffffff;
                    else if (pos_n < -57'sh800000000000) r_pos[ax] <= 48'sh800000000000;
                    else r_pos[ax] <= pos_n[47:0];
                end
                idr_pkg::OP_VEL: begin
                    if (vel_n > 41'sh7fffffff) r_vel[ax] <= 32'sh7fffffff;
                    else if (vel_n < -41'sh80000000) r_vel[ax] <= 32'sh80000000;
                    else r_vel[ax] <= vel_n[31:0];
                    if (ax == 2'd2) begin
                        if (!r_full) r_fill <= r_fill + 1'b1;
                        r_full <= r_full || (r_fill + 1'b1 >= idr_pkg::SlotW'(idr_pkg::Window));
                        r_slot <= (r_slot + 1'b1 >= idr_pkg::SlotW'(idr_pkg::Window))
                                  ? '0 : r_slot + 1'b1;
                    end
                end
                idr_pkg::OP_DONE: r_obusy <= 1'b1;
                default: ;
            endcase
            // Restoring divider for |sum| * 2 + n over 2n, one bit a cycle.
            if (!r_dbusy && r_dpend != 2'd0 && i_cmd.op != idr_pkg::OP_SUM
                && i_cmd.op != idr_pkg::OP_WRD) begin
                r_dneg  <= r_sum[r_daxis][idr_pkg::SumW-1];
                r_dnum  <= (DivW'(r_sum[r_daxis][idr_pkg::SumW-1]
                            ? -r_sum[r_daxis] : r_sum[r_daxis]) << 1)
                           + DivW'(r_fill + (r_full ? 1'b0 : 1'b1));
                r_dden  <= DivW'(r_fill + (r_full ? 1'b0 : 1'b1)) << 1;
                r_drem  <= '0;
                r_dcnt  <= CntW'(DivW);
                r_dbusy <= 1'b1;
                r_dpend <= r_dpend - 2'd1;
            end else if (r_dbusy) begin
                if (r_dcnt == '0) begin
                    r_dbusy <= 1'b0;
                    if (r_dq > DivW'(32768) || (r_dq == DivW'(32768) && !r_dneg)) begin
                        r_sacc[r_daxis] <= r_dneg ? 16'sh8000 : 16'sh7fff;
                    end else begin
                        r_sacc[r_daxis] <= r_dneg ? 16'(-r_dq[15:0]) : r_dq[15:0];
                    end
                end else begin
                    r_dcnt <= r_dcnt - 1'b1;
                    r_dnum <= r_dnum << 1;
                    if (d_try >= r_dden) begin
                        r_drem <= d_try - r_dden;
                        r_dq   <= {r_dq[DivW-2:0], 1'b1};
                    end else begin
                        r_drem <= d_try;
                        r_dq   <= {r_dq[DivW-2:0], 1'b0};
                    end
                end
            end else begin
                r_dq <= '0;
            end
        end
    end

    assign out_if.valid        = r_obusy;
    assign out_if.pos_x        = r_pos[0];
    assign out_if.pos_y        = r_pos[1];
    assign out_if.pos_z        = r_pos[2];
    assign out_if.vel_x        = r_vel[0];
    assign out_if.vel_y        = r_vel[1];
    assign out_if.vel_z        = r_vel[2];
    assign out_if.smooth_acc_x = r_sacc[0];
    assign out_if.smooth_acc_y = r_sacc[1];
    assign out_if.smooth_acc_z = r_sacc[2];
endmodule
`default_nettype wire

/* rtl/inertial_dead_reckoning.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "inertial_dead_reckoning_defines.svh"
// ----------------------------------------------------------------------------
// Inertial dead reckoning
// Strapdown position and velocity from rotated, averaged acceleration.
// ----------------------------------------------------------------------------
// One sample is taken at a time: the sample is latched and rotated, then each
// axis in turn updates its moving-average window, waits on the bit-serial
// divider for the average and integrates position and velocity, and the
// result beat is then presented.
// A new sample is accepted once the previous result beat has been taken.
// Gravity is set through the register port at byte address 0.
module inertial_dead_reckoning (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    idr_in_if.sink           in_if,
    idr_out_if.source        out_if,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [14:0]     r_gravity;
    idr_pkg::t_cmd   cmd;
    idr_pkg::t_stat  stat;
    logic            ctrl_ready;

    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == {idr_pkg::RegGravity, 1'b0}) ? {17'd0, r_gravity} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= idr_pkg::GravityReset;
        end else if (psel && penable && pwrite && paddr == {idr_pkg::RegGravity, 1'b0}) begin
            r_gravity <= pwdata[14:0];
        end
    end

    idr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_if.valid),
        .o_in_ready (ctrl_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    idr_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_ready (ctrl_ready),
        .o_stat     (stat),
        .i_gravity  (r_gravity),
        .in_if      (in_if),
        .out_if     (out_if)
    );

    `IDR_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, in_if.ready, ctrl_ready)
    `IDR_ASSERT_NXT(a_load, i_clk, i_rst_n, in_if.valid && in_if.ready,
                    cmd.op == idr_pkg::OP_LOAD)
    `IDR_ASSERT_IMP(a_no_out_busy, i_clk, i_rst_n, out_if.valid, !in_if.ready)
endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dead reckoning block testbench
// Streams orientation, acceleration and timestamp samples through the block
// with random gaps and output stalls, predicts every navigation beat in a
// fixed-point model of its own and compares the beats field by field.
// ----------------------------------------------------------------------------
module tb_top;
    localparam int WatchdogLimit = 20000;
    localparam int NumFields     = 9;

    typedef struct {
        logic [47:0]        row0;
        logic [47:0]        row1;
        logic [47:0]        row2;
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic signed [15:0] acc_z;
        logic [31:0]        stamp;
    } t_sample;

    typedef struct {
        longint f [NumFields];
    } t_nav;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    idr_in_if  in_bus ();
    idr_out_if out_bus ();

    inertial_dead_reckoning dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_if   (in_bus),
        .out_if  (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state
    logic [31:0]        nav_last_stamp;
    shortint            nav_window [3][idr_pkg::Window];
    longint             nav_sum [3];
    int                 nav_fill;
    int                 nav_slot;
    longint             nav_vel [3];
    longint             nav_pos [3];
    longint             nav_acc [3];
    logic [14:0]        nav_gravity;

    t_nav   nav_expected [$];
    int     mismatch_count;
    int     idle_cycles;
    int     stall_left;
    bit     no_idle;
    string  field_names [NumFields] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y",
                                        "vel_z", "smooth_acc_x", "smooth_acc_y",
                                        "smooth_acc_z"};

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic longint sat_to(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // round(x * d / 2^k), half away from zero, without losing any bits
    function automatic longint scaled_round(longint x, longint unsigned d, int k);
        longint unsigned m, mask, lo, q;
        m    = (x < 0) ? longint'(-x) : x;
        mask = (64'd1 << k) - 1;
        lo   = (m & mask) * d;
        q    = (m >> k) * d + (lo >> k);
        if ((lo & mask) >= (64'd1 << (k - 1))) q++;
        return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint window_mean(longint total, int n);
        longint unsigned m, q;
        if (n == 0) return 0;
        m = (total < 0) ? -total : total;
        q = (2 * m + n) / (2 * longint'(n));
        return sat_to((total < 0) ? -longint'(q) : longint'(q), 16);
    endfunction

    task automatic predict_navigation(input t_sample s);
        logic [31:0] dt;
        longint      rot [3][3];
        longint      body [3];
        longint      glob [3];
        longint      acc;
        bit          full;
        t_nav        res;
        dt = s.stamp - nav_last_stamp;
        nav_last_stamp = s.stamp;
        full = nav_fill >= idr_pkg::Window;
        for (int j = 0; j < 3; j++) begin
            rot[0][j] = longint'($signed(s.row0[16*j +: 16]));
            rot[1][j] = longint'($signed(s.row1[16*j +: 16]));
            rot[2][j] = longint'($signed(s.row2[16*j +: 16]));
        end
        body[0] = longint'(s.acc_x);
        body[1] = longint'(s.acc_y);
        body[2] = longint'(s.acc_z);
        // Position uses the acceleration and velocity from before this sample.
        for (int j = 0; j < 3; j++) begin
            nav_pos[j] = sat_to(nav_pos[j]
                + scaled_round(nav_acc[j] * longint'({32'd0, dt}), {32'd0, dt}, 25)
                + scaled_round(nav_vel[j], {32'd0, dt}, 16), 48);
        end
        for (int j = 0; j < 3; j++) begin
            acc = rot[0][j] * body[0] + rot[1][j] * body[1] + rot[2][j] * body[2];
            acc = scaled_round(acc, 64'd1, 14);
            if (j == 2) acc -= longint'({49'd0, nav_gravity});
            glob[j] = sat_to(acc, 16);
        end
        for (int j = 0; j < 3; j++) begin
            if (full) nav_sum[j] -= nav_window[j][nav_slot];
            nav_window[j][nav_slot] = shortint'(glob[j]);
            nav_sum[j] += glob[j];
        end
        if (!full) nav_fill++;
        nav_slot = (nav_slot + 1 >= idr_pkg::Window) ? 0 : nav_slot + 1;
        for (int j = 0; j < 3; j++) begin
            nav_acc[j] = window_mean(nav_sum[j], nav_fill);
            nav_vel[j] = sat_to(nav_vel[j] + scaled_round(nav_acc[j], {32'd0, dt}, 8), 32);
            res.f[j]     = nav_pos[j];
            res.f[3 + j] = nav_vel[j];
            res.f[6 + j] = nav_acc[j];
        end
        nav_expected.push_back(res);
    endtask

    task automatic send_sample(input t_sample s);
        int gap;
        in_bus.valid      <= 1'b1;
        in_bus.rot_row0   <= s.row0;
        in_bus.rot_row1   <= s.row1;
        in_bus.rot_row2   <= s.row2;
        in_bus.body_acc_x <= s.acc_x;
        in_bus.body_acc_y <= s.acc_y;
        in_bus.body_acc_z <= s.acc_z;
        in_bus.time_stamp <= s.stamp;
        do @(posedge i_clk); while (!in_bus.ready);
        predict_navigation(s);
        gap = no_idle ? 0 : (($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                         : $urandom_range(10, 60));
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        in_bus.valid <= 1'b0;
        while (nav_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_gravity(input logic [14:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'(idr_pkg::RegGravity);
        pwdata  <= {17'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        nav_gravity = value;
    endtask

    task automatic check_gravity_readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 2'(idr_pkg::RegGravity);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[14:0] !== nav_gravity) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("gravity read: expected %0d got %0d", nav_gravity, prdata[14:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_sample random_sample(input logic [31:0] max_step);
        t_sample s;
        s.row0  = 48'({$urandom(), $urandom()});
        s.row1  = 48'({$urandom(), $urandom()});
        s.row2  = 48'({$urandom(), $urandom()});
        // Mostly near-rotation matrices so the outputs do not sit at their limits.
        if ($urandom_range(0, 3) != 0) begin
            s.row0 = {16'($urandom_range(0, 255) - 128), 16'($urandom_range(0, 255) - 128),
                      16'(16384 - $urandom_range(0, 255))};
            s.row1 = {16'($urandom_range(0, 255) - 128), 16'(16384 - $urandom_range(0, 255)),
                      16'($urandom_range(0, 255) - 128)};
            s.row2 = {16'(16384 - $urandom_range(0, 255)), 16'($urandom_range(0, 255) - 128),
                      16'($urandom_range(0, 255) - 128)};
        end
        s.acc_x = 16'($urandom());
        s.acc_y = 16'($urandom());
        s.acc_z = 16'($urandom());
        if ($urandom_range(0, 1) == 0) begin
            s.acc_x = 16'($urandom_range(0, 1023) - 512);
            s.acc_y = 16'($urandom_range(0, 1023) - 512);
            s.acc_z = 16'($urandom_range(0, 1023) + 2000);
        end
        case ($urandom_range(0, 19))
            0:       s.stamp = nav_last_stamp - $urandom_range(1, 5000);
            1:       s.stamp = $urandom();
            2:       s.stamp = nav_last_stamp;
            default: s.stamp = nav_last_stamp + $urandom_range(1, max_step);
        endcase
        return s;
    endfunction

    task automatic test_directed;
        t_sample s;
        // Identity orientation, level sensor reading plain gravity.
        s = '{48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000,
              16'sd0, 16'sd0, 16'sd2511, 32'h0000_0100};
        send_sample(s);
        send_sample(random_sample(100));
        // Extremes of every field.
        s = '{48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
              16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'h0001_0000};
        send_sample(s);
        s = '{48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
              16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'h0002_0000};
        send_sample(s);
        s = '{48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
              -16'sh8000, -16'sh8000, -16'sh8000, 32'h0003_0000};
        send_sample(s);
        s = '{48'hFFFF_FFFF_FFFF, 48'h0, 48'hFFFF_FFFF_FFFF,
              -16'sd1, 16'sd0, -16'sh8000, 32'hFFFF_FFFF};
        send_sample(s);
        // Timestamp wrapping past zero gives a small step; going backwards wraps into a very large step.
        s.stamp = 32'h0000_0001;
        send_sample(s);
        s = '{48'h0, 48'h0, 48'h0, 16'sd0, 16'sd0, 16'sd0, 32'h0000_0001};
        send_sample(s);
        s.stamp = 32'h0000_0000;
        send_sample(s);
        s.stamp = 32'hFFFF_FFFF;
        send_sample(s);
        repeat (10) send_sample(random_sample(32'h0004_0000));
        drain();
    endtask

    // Runs well past the window length so that old samples leave the sums.
    task automatic test_gravity_settings;
        logic [14:0] settings [5] = '{15'd0, 15'h7FFF, 15'd2511, 15'd1, 15'd0};
        settings[4] = 15'($urandom());
        foreach (settings[k]) begin
            write_gravity(settings[k]);
            check_gravity_readback();
            no_idle = (k == 1);
            repeat (90) send_sample(random_sample(3000));
            drain();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_stream;
        for (int n = 0; n < 1480; n++) begin
            no_idle = (n % 400) > 320;
            send_sample(random_sample((n % 5 == 0) ? 32'h0010_0000 : 32'd2000));
        end
        no_idle = 1'b0;
        drain();
    endtask

    // Result check and watchdog
    always @(posedge i_clk) begin
        t_nav got;
        t_nav want;
        if (i_rst_n) begin
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
                    || psel) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WatchdogLimit) begin
                $display("tb_top NOT OK");
                $finish;
            end
            if (out_bus.valid && out_bus.ready) begin
                got.f = '{out_bus.pos_x, out_bus.pos_y, out_bus.pos_z, out_bus.vel_x,
                          out_bus.vel_y, out_bus.vel_z, out_bus.smooth_acc_x,
                          out_bus.smooth_acc_y, out_bus.smooth_acc_z};
                if (nav_expected.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) $display("unexpected result beat");
                end else begin
                    want = nav_expected.pop_front();
                    for (int k = 0; k < NumFields; k++) begin
                        if (got.f[k] != want.f[k]) begin
                            mismatch_count++;
                            if (mismatch_count <= 10)
                                $display("%s: expected %0d got %0d", field_names[k],
                                         want.f[k], got.f[k]);
                        end
                    end
                end
            end
        end
    end

    // Output back-pressure: short random stalls with the odd long one.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            out_bus.ready <= 1'b0;
        end else if (no_idle) begin
            out_bus.ready <= 1'b1;
        end else begin
            if ($urandom_range(0, 40) == 0) stall_left <= $urandom_range(10, 80);
            out_bus.ready <= ($urandom_range(0, 9) < 7);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.rot_row0 = '0;
        in_bus.rot_row1 = '0;
        in_bus.rot_row2 = '0;
        in_bus.body_acc_x = '0;
        in_bus.body_acc_y = '0;
        in_bus.body_acc_z = '0;
        in_bus.time_stamp = '0;
        out_bus.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stall_left = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        mismatch_count = 0;
        nav_last_stamp = '0;
        nav_fill = 0;
        nav_slot = 0;
        nav_gravity = idr_pkg::GravityReset;
        for (int j = 0; j < 3; j++) begin
            nav_sum[j] = 0;
            nav_vel[j] = 0;
            nav_pos[j] = 0;
            nav_acc[j] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_gravity_readback();
        test_directed();
        test_gravity_settings();
        test_random_stream();
        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/idr_pkg.sv
rtl/idr_stream_if.sv
rtl/idr_ctrl.sv
rtl/idr_dpath.sv
rtl/inertial_dead_reckoning.sv
sim/tb_top.sv
